// ===== src/sfrsc_pkg.sv =====
// Shared types, constants and register codes for the serial frame receiver.
// No dependencies; every other file of the block but sfrsc_ram imports this package.
`timescale 1ns / 1ps

package sfrsc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 8;

    // Longest run that the 5-bit position can number.
    localparam int unsigned RUN_CAP = 32;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 32;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [LEN_W-1:0]  t_len;

    // Register indexes on the configuration port
    localparam logic [CIDX_W-1:0] CFG_IDX_HEAD = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IDX_MIN  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_IDX_MAX  = 2'd2;

    localparam t_byte HEAD_BYTE_RST = 8'h42;
    localparam t_len  MIN_LEN_RST   = 6'd4;
    localparam t_len  MAX_LEN_RST   = 6'd32;

    typedef struct packed {
        t_byte head_byte;
        t_len  min_frame_len;
        t_len  max_frame_len;
    } t_cfg;

endpackage

// ===== src/sfrsc_if.sv =====
// Stream interfaces of the frame receiver: received bytes in, frame words out.
// Depends on sfrsc_pkg for the field types.
`timescale 1ns / 1ps

interface sfrsc_in_if import sfrsc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfrsc_out_if import sfrsc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte frame_byte;
    t_pos  byte_position;
    logic  last_of_frame;
    logic  status;

    modport source (output valid, output frame_byte, output byte_position,
                    output last_of_frame, output status, input ready);
    modport sink   (input valid, input frame_byte, input byte_position,
                    input last_of_frame, input status, output ready);
endinterface

// ===== src/sfrsc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfrsc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sfrsc_cfg.sv =====
// Configuration registers of the frame receiver, written through a plain write port.
// Depends on sfrsc_pkg.
`timescale 1ns / 1ps

module sfrsc_cfg import sfrsc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_idx,
    input  logic [CDATA_W-1:0]  i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_HEAD: n_cfg.head_byte     = i_cfg_data;
                CFG_IDX_MIN:  n_cfg.min_frame_len = i_cfg_data[LEN_W-1:0];
                CFG_IDX_MAX:  n_cfg.max_frame_len = i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte     <= HEAD_BYTE_RST;
            r_cfg.min_frame_len <= MIN_LEN_RST;
            r_cfg.max_frame_len <= MAX_LEN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/sfrsc_ctrl.sv =====
// Frame assembly, checksum check and run emission around the frame store RAM.
// Each entry holds {running sum of earlier bytes, byte}. Depends on sfrsc_pkg,
// sfrsc_if and sfrsc_ram.
`timescale 1ns / 1ps

module sfrsc_ctrl import sfrsc_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    sfrsc_in_if.sink           i_rx,
    sfrsc_out_if.source        o_frm
);

    localparam int unsigned DEPTH   = (MAX_FRAME_BYTES < RUN_CAP) ? MAX_FRAME_BYTES : RUN_CAP;
    localparam int unsigned AW      = $clog2(DEPTH);
    localparam int unsigned ENTRY_W = 2 * BYTE_W;
    localparam t_len        LIM_CAP = LEN_W'(DEPTH);
    localparam t_len        LEN_ONE = LEN_W'(1);
    localparam t_len        LEN_TWO = LEN_W'(2);
    localparam t_len        LEN_THREE = LEN_W'(3);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK,
        S_RD,
        S_LOAD
    } t_state;

    t_state r_state, n_state;
    logic   r_in_frame, n_in_frame;
    t_len   r_wi, n_wi;
    t_byte  r_dl, n_dl;
    t_byte  r_sum, n_sum;
    t_len   r_len, n_len;
    t_pos   r_pos, n_pos;

    logic   r_ov, n_ov;
    t_byte  r_ob, n_ob;
    t_pos   r_op, n_op;
    logic   r_ol, n_ol;
    logic   r_os, n_os;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    sfrsc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    t_byte b;
    t_len  lim;
    t_len  minl;
    logic  acc;
    logic  out_free;
    logic  done;
    t_byte len8;
    t_byte rd_prefix;
    t_byte rd_byte;
    logic  pos_last;

    assign b         = i_rx.rx_byte;
    assign minl      = i_cfg.min_frame_len;
    assign lim       = (i_cfg.max_frame_len < LIM_CAP) ? i_cfg.max_frame_len : LIM_CAP;
    assign acc       = i_rx.valid && (r_state == S_IDLE);
    assign out_free  = !r_ov || o_frm.ready;
    assign rd_prefix = ram_rdata[ENTRY_W-1:BYTE_W];
    assign rd_byte   = ram_rdata[BYTE_W-1:0];
    assign pos_last  = ((LEN_W'(r_pos) + LEN_ONE) == r_len);

    always_comb begin
        n_state    = r_state;
        n_in_frame = r_in_frame;
        n_wi       = r_wi;
        n_dl       = r_dl;
        n_sum      = r_sum;
        n_len      = r_len;
        n_pos      = r_pos;
        n_ov       = r_ov && !o_frm.ready;
        n_ob       = r_ob;
        n_op       = r_op;
        n_ol       = r_ol;
        n_os       = r_os;
        ram_we     = 1'b0;
        ram_waddr  = r_wi[AW-1:0];
        ram_wdata  = {r_sum, b};
        ram_re     = 1'b0;
        ram_raddr  = r_pos[AW-1:0];
        done       = 1'b0;
        len8       = r_dl;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (b == i_cfg.head_byte && !r_in_frame) begin
                        n_in_frame = 1'b1;
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = {{BYTE_W{1'b0}}, b};
                        n_sum      = b;
                        n_dl       = BYTE_W'(minl);
                        n_wi       = LEN_ONE;
                    end else if (r_wi == LEN_TWO) begin
                        // length byte
                        ram_we = 1'b1;
                        n_sum  = r_sum + b;
                        n_wi   = LEN_THREE;
                        n_dl   = b;
                        if (b > BYTE_W'(lim) || b < BYTE_W'(minl)) begin
                            n_dl       = BYTE_W'(minl);
                            n_wi       = '0;
                            n_in_frame = 1'b0;
                        end
                    end else if (r_in_frame && r_wi < lim) begin
                        ram_we = 1'b1;
                        n_sum  = r_sum + b;
                        n_wi   = r_wi + LEN_ONE;
                    end

                    done = (n_wi >= lim || BYTE_W'(n_wi) >= n_dl) && n_wi > minl;
                    len8 = (n_dl > BYTE_W'(n_wi)) ? BYTE_W'(n_wi) : n_dl;
                    if (done) begin
                        n_len      = (len8 == '0) ? LEN_ONE : len8[LEN_W-1:0];
                        n_wi       = '0;
                        n_in_frame = 1'b0;
                        n_state    = S_CHK_RD;
                    end
                end
            end
            S_CHK_RD: begin
                // last byte of the run and the sum of all bytes before it
                ram_re    = 1'b1;
                ram_raddr = AW'(r_len - LEN_ONE);
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (rd_prefix == rd_byte) begin
                    n_pos   = '0;
                    n_state = S_RD;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_ob    = '0;
                    n_op    = '0;
                    n_ol    = 1'b1;
                    n_os    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ob = rd_byte;
                    n_op = r_pos;
                    n_ol = pos_last;
                    n_os = 1'b0;
                    if (pos_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_frame <= 1'b0;
            r_wi       <= '0;
            r_dl       <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_frame <= n_in_frame;
            r_wi       <= n_wi;
            r_dl       <= n_dl;
            r_ov       <= n_ov;
        end
        r_sum <= n_sum;
        r_len <= n_len;
        r_pos <= n_pos;
        r_ob  <= n_ob;
        r_op  <= n_op;
        r_ol  <= n_ol;
        r_os  <= n_os;
    end

    assign i_rx.ready          = (r_state == S_IDLE);
    assign o_frm.valid         = r_ov;
    assign o_frm.frame_byte    = r_ob;
    assign o_frm.byte_position = r_op;
    assign o_frm.last_of_frame = r_ol;
    assign o_frm.status        = r_os;

endmodule

// ===== src/serial_frame_receiver_sum_check.sv =====
// Top level of the serial frame receiver with additive checksum check.
// Depends on sfrsc_pkg, sfrsc_if, sfrsc_cfg and sfrsc_ctrl.
//
//   channel   dir  handshake         word
//   i_rx      in   valid/ready       rx_byte
//   o_frm     out  valid/ready       frame_byte, byte_position, last_of_frame, status
//   cfg       in   i_cfg_we          i_cfg_idx, i_cfg_data
//
// A byte that does not close a frame is taken and ready stays high. A closing byte
// starts the checksum read in S_CHK_RD and S_CHK. A failed check sends one status
// word; else each word is read in S_RD and S_LOAD on the store's single read port.
// Input is held off while a frame is read out; the output register lets the next
// byte in while the last word of a frame still waits. Reset is synchronous and
// clears control state only; the frame store is never cleared.
`timescale 1ns / 1ps

module serial_frame_receiver_sum_check import sfrsc_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sfrsc_in_if.sink           i_rx,
    sfrsc_out_if.source        o_frm,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CDATA_W-1:0] i_cfg_data
);

    t_cfg cfg;

    sfrsc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sfrsc_ctrl #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_rx    (i_rx),
        .o_frm   (o_frm)
    );

endmodule
